FILE: design/rwts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwts_pkg: shared types and constants for the wall texel shader
// Field widths, texture codes, operation codes and shading constants.
// ----------------------------------------------------------------------------
package rwts_pkg;

    // field widths of the beats and the register
    localparam int SCREEN_H_W = 13;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 12;
    localparam int FRAC_W     = 16;
    localparam int SLICE_W    = 16;
    localparam int COLOR_W    = 24;
    localparam int TEX_ADDR_W = 12;
    localparam int TEX_SEL_W  = 2;

    // signed slice offset: row - height/2 + slice/2 needs two bits over the slice
    localparam int T_W = SLICE_W + 2;

    localparam logic [SCREEN_H_W-1:0] SCREEN_H_RESET = 13'd480;

    // four textures of 2**TEX_ADDR_W texels each
    localparam int TEX_COUNT  = 4;
    localparam int TEX_DEPTH  = TEX_COUNT * (1 << TEX_ADDR_W);

    localparam int TEX_SIZE_DEFAULT = 64;

    // restoring divider: quotient bits resolved per pipeline stage
    localparam int DIV_STEPS = 4;

    // clears the bit shifted in from the next channel after halving
    localparam logic [COLOR_W-1:0] DARKEN_MASK = 24'h7F7F7F;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_SHADE = 1'b1
    } t_op;

    typedef enum logic [TEX_SEL_W-1:0] {
        TEX_NORTH = 2'd0,
        TEX_SOUTH = 2'd1,
        TEX_EAST  = 2'd2,
        TEX_WEST  = 2'd3
    } t_tex;

endpackage

FILE: design/rwts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwts_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module rwts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/rwts_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwts_div_stage: one stage of the pipelined restoring divider
// Resolves STEPS quotient bits, keeps the low Q_W of them, and carries the
// remainder, the remaining dividend bits, the divisor and a sideband word.
// ----------------------------------------------------------------------------
module rwts_div_stage #(
    parameter int NUM_W  = 22,
    parameter int Q_W    = 6,
    parameter int DEN_W  = 16,
    parameter int STEPS  = 4,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_rem,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [Q_W-1:0]    i_quo,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_num,
    output logic [DEN_W-1:0]  o_rem,
    output logic [DEN_W-1:0]  o_den,
    output logic [Q_W-1:0]    o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [Q_W-1:0]    r_quo;
    logic [SIDE_W-1:0] r_side;

    logic [NUM_W-1:0]  n_num;
    logic [DEN_W-1:0]  n_rem;
    logic [Q_W-1:0]    n_quo;
    logic [DEN_W:0]    w_trial;
    logic              w_qbit;

    // restoring steps: shift in the next dividend bit, subtract if it fits
    always_comb begin
        n_num   = i_num;
        n_rem   = i_rem;
        n_quo   = i_quo;
        w_trial = '0;
        w_qbit  = 1'b0;
        for (int s = 0; s < STEPS; s++) begin
            w_trial = {n_rem, n_num[NUM_W-1]};
            n_num   = n_num << 1;
            w_qbit  = (w_trial >= {1'b0, i_den});
            if (w_qbit) begin
                n_rem = DEN_W'(w_trial - {1'b0, i_den});
            end else begin
                n_rem = DEN_W'(w_trial);
            end
            n_quo = Q_W'({n_quo, w_qbit});
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

`ifndef NO_ASSERTIONS
    // a partial remainder never reaches the divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");
`endif

endmodule

FILE: design/raycast_wall_texel_shader_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raycast_wall_texel_shader_unit: textured wall column pixel shader
// Loads texels into a four-texture store and shades raycast wall pixels.
// ----------------------------------------------------------------------------
// Takes one beat per clock and returns one beat per clock while the output is
// not stalled, loads and shades alike, in order. It has one front stage, the
// restoring divider that finds the texture row at up to four quotient bits
// per stage, one stage for the texture store read and one output register.
// Loads write the store in the same stage in which shades read it, so a shade
// sees every load given before it. TEX_SIZE must be a power of two. The output
// register lets the pipeline keep filling while a result waits; stall reaches
// back only over stages that hold a beat. The user must write screen_height
// through the config port only while the unit is idle; the unit itself does
// not enforce this. The config port is always ready.
// ----------------------------------------------------------------------------
module raycast_wall_texel_shader_unit #(
    parameter int TEX_SIZE = rwts_pkg::TEX_SIZE_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rwts_pkg::SCREEN_H_W-1:0] i_cfg_data,
    // input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_operation,
    input  logic [rwts_pkg::TEX_SEL_W-1:0]  i_texture_select,
    input  logic [rwts_pkg::TEX_ADDR_W-1:0] i_texel_address,
    input  logic [rwts_pkg::COLOR_W-1:0]    i_texel_value,
    input  logic                            i_hit_side,
    input  logic                            i_dir_x_negative,
    input  logic                            i_dir_y_positive,
    input  logic [rwts_pkg::FRAC_W-1:0]     i_wall_fraction,
    input  logic [rwts_pkg::SLICE_W-1:0]    i_slice_height,
    input  logic [rwts_pkg::ROW_W-1:0]      i_pixel_row,
    input  logic [rwts_pkg::COL_W-1:0]      i_pixel_column,
    // output channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [rwts_pkg::COLOR_W-1:0]    o_pixel_color,
    output logic                            o_write_pixel,
    output logic [rwts_pkg::ROW_W-1:0]      o_out_row,
    output logic [rwts_pkg::COL_W-1:0]      o_out_column
);

    import rwts_pkg::*;

    localparam int TEX_LOG  = $clog2(TEX_SIZE);
    localparam int NUM_W    = SLICE_W + TEX_LOG;
    localparam int NS       = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int RAM_AW   = $clog2(TEX_DEPTH);

    typedef struct packed {
        t_op                   op;
        t_tex                  tex;
        logic                  neg;
        logic [TEX_LOG-1:0]    tx;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic [TEX_ADDR_W-1:0] ld_addr;
        logic [COLOR_W-1:0]    ld_value;
    } t_side;

    localparam int SIDE_W = $bits(t_side);

    // configuration register
    logic [SCREEN_H_W-1:0] r_screen_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_h <= SCREEN_H_RESET;
        end else if (i_cfg_valid) begin
            r_screen_h <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipeline chain signals; index 0 is the front stage
    logic              w_div_valid [NS+1];
    logic              w_div_rdy   [NS+1];
    logic [NUM_W-1:0]  w_num       [NS+1];
    logic [SLICE_W-1:0] w_rem      [NS+1];
    logic [SLICE_W-1:0] w_den      [NS+1];
    logic [TEX_LOG-1:0] w_quo      [NS+1];
    logic [SIDE_W-1:0] w_side      [NS+1];
    logic              w_rd_rdy;
    logic              w_out_rdy;

    // ---------------- front stage ----------------
    logic               r_f_valid;
    t_side              r_f_side;
    logic [NUM_W-1:0]   r_f_num;
    logic [SLICE_W-1:0] r_f_den;

    t_side              n_f_side;
    t_tex               w_pick;
    logic [TEX_LOG-1:0] w_tx;
    logic [T_W-1:0]     w_t;
    logic [SLICE_W-1:0] w_abs_t;
    logic [SLICE_W-1:0] w_lh;

    // texture from hit side and direction signs, column from wall fraction
    always_comb begin
        if (i_hit_side) begin
            w_pick = i_dir_y_positive ? TEX_SOUTH : TEX_NORTH;
        end else begin
            w_pick = i_dir_x_negative ? TEX_WEST : TEX_EAST;
        end
        w_tx = i_wall_fraction[FRAC_W-1 -: TEX_LOG];
        if (w_pick == TEX_WEST || w_pick == TEX_SOUTH) begin
            w_tx = ~w_tx;
        end
    end

    // slice offset t and its magnitude; a zero slice height counts as one
    always_comb begin
        w_lh    = (i_slice_height == '0) ? SLICE_W'(1) : i_slice_height;
        w_t     = T_W'(i_pixel_row) - T_W'(r_screen_h >> 1) + T_W'(w_lh >> 1);
        w_abs_t = w_t[T_W-1] ? SLICE_W'(T_W'(0) - w_t) : SLICE_W'(w_t);
    end

    always_comb begin
        n_f_side.op       = t_op'(i_operation);
        n_f_side.tex      = (t_op'(i_operation) == OP_LOAD) ? t_tex'(i_texture_select)
                                                            : w_pick;
        n_f_side.neg      = w_t[T_W-1];
        n_f_side.tx       = w_tx;
        n_f_side.row      = i_pixel_row;
        n_f_side.col      = i_pixel_column;
        n_f_side.ld_addr  = i_texel_address;
        n_f_side.ld_value = i_texel_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_div_rdy[0]) begin
            r_f_valid <= i_valid;
        end
        if (w_div_rdy[0]) begin
            r_f_side <= n_f_side;
            r_f_num  <= {w_abs_t, {TEX_LOG{1'b0}}};
            r_f_den  <= w_lh;
        end
    end

    assign o_stall        = !w_div_rdy[0];
    assign w_div_valid[0] = r_f_valid;
    assign w_num[0]       = r_f_num;
    assign w_rem[0]       = '0;
    assign w_den[0]       = r_f_den;
    assign w_quo[0]       = '0;
    assign w_side[0]      = r_f_side;

    // ---------------- divider stages ----------------
    // dividend |t| * TEX_SIZE; the low quotient bits are the texture row
    for (genvar g = 0; g < NS; g++) begin : g_div
        localparam int LEFT  = NUM_W - g * DIV_STEPS;
        localparam int STEPS = (LEFT < DIV_STEPS) ? LEFT : DIV_STEPS;

        rwts_div_stage #(
            .NUM_W  (NUM_W),
            .Q_W    (TEX_LOG),
            .DEN_W  (SLICE_W),
            .STEPS  (STEPS),
            .SIDE_W (SIDE_W)
        ) u_div_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_div_rdy[g+1]),
            .i_valid (w_div_valid[g]),
            .i_num   (w_num[g]),
            .i_rem   (w_rem[g]),
            .i_den   (w_den[g]),
            .i_quo   (w_quo[g]),
            .i_side  (w_side[g]),
            .o_valid (w_div_valid[g+1]),
            .o_num   (w_num[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_den   (w_den[g+1]),
            .o_quo   (w_quo[g+1]),
            .o_side  (w_side[g+1])
        );

        assign w_div_rdy[g] = !w_div_valid[g] || w_div_rdy[g+1];
    end

    assign w_div_rdy[NS] = !w_div_valid[NS] || w_rd_rdy;

    // ---------------- texture store access ----------------
    t_side                 w_last;
    logic                  w_nz;
    logic [TEX_LOG-1:0]    w_ty;
    logic [TEX_ADDR_W-1:0] w_texel;
    logic                  w_ram_we;
    logic [COLOR_W-1:0]    w_rd_data;

    // floor for a negative offset: negate and round away when inexact
    always_comb begin
        w_last  = t_side'(w_side[NS]);
        w_nz    = |w_rem[NS];
        w_ty    = w_last.neg ? TEX_LOG'(TEX_LOG'(0) - w_quo[NS] - TEX_LOG'(w_nz))
                             : w_quo[NS];
        w_texel = TEX_ADDR_W'({w_ty, w_last.tx});
    end

    assign w_ram_we = w_div_valid[NS] && (w_last.op == OP_LOAD) && w_rd_rdy;

    rwts_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (TEX_DEPTH)
    ) u_tex_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (RAM_AW'({w_last.tex, w_last.ld_addr})),
        .i_wr_data (w_last.ld_value),
        .i_rd_en   (w_rd_rdy),
        .i_rd_addr (RAM_AW'({w_last.tex, w_texel})),
        .o_rd_data (w_rd_data)
    );

    // sideband alongside the registered read data
    logic             r_rd_valid;
    t_op              r_rd_op;
    t_tex             r_rd_tex;
    logic [ROW_W-1:0] r_rd_row;
    logic [COL_W-1:0] r_rd_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (w_rd_rdy) begin
            r_rd_valid <= w_div_valid[NS];
        end
        if (w_rd_rdy) begin
            r_rd_op  <= w_last.op;
            r_rd_tex <= w_last.tex;
            r_rd_row <= w_last.row;
            r_rd_col <= w_last.col;
        end
    end

    assign w_rd_rdy = !r_rd_valid || w_out_rdy;

    // ---------------- shading and output register ----------------
    logic               r_out_valid;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_write;
    logic [ROW_W-1:0]   r_out_row;
    logic [COL_W-1:0]   r_out_col;
    logic [COLOR_W-1:0] n_color;

    // north and east faces are darkened; load beats give zeros
    always_comb begin
        n_color = w_rd_data;
        if (r_rd_tex == TEX_NORTH || r_rd_tex == TEX_EAST) begin
            n_color = (w_rd_data >> 1) & DARKEN_MASK;
        end
        if (r_rd_op == OP_LOAD) begin
            n_color = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_valid <= r_rd_valid;
        end
        if (w_out_rdy) begin
            r_out_color <= n_color;
            r_out_write <= |n_color;
            r_out_row   <= (r_rd_op == OP_LOAD) ? '0 : r_rd_row;
            r_out_col   <= (r_rd_op == OP_LOAD) ? '0 : r_rd_col;
        end
    end

    assign w_out_rdy     = !r_out_valid || !i_stall;
    assign o_valid       = r_out_valid;
    assign o_pixel_color = r_out_color;
    assign o_write_pixel = r_out_write;
    assign o_out_row     = r_out_row;
    assign o_out_column  = r_out_col;

`ifndef NO_ASSERTIONS
    // a beat leaving the divider lands in the read stage
    a_div_to_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_valid[NS] && w_rd_rdy) |=> r_rd_valid)
        else $error("beat lost between divider and store read");

    // a texel write belongs to a load beat that then sits in the read stage
    a_we_is_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |=> (r_rd_valid && r_rd_op == OP_LOAD))
        else $error("texture store written by a non-load beat");

    // a result only appears after the read stage held a beat
    a_out_from_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_rd_valid))
        else $error("output valid without a beat in the read stage");
`endif

endmodule
